// ----- rtl/core/rcp_pkg.sv -----
// Shared types and constants for the rotator command parser.
// No dependencies; imported by every other file of the block but rcp_if.
`default_nettype none

package rcp_pkg;

   localparam logic [2:0] KIND_SETPOINT = 3'd0;
   localparam logic [2:0] KIND_MOVE_POS = 3'd1;
   localparam logic [2:0] KIND_MOVE_NEG = 3'd2;
   localparam logic [2:0] KIND_STOP     = 3'd3;
   localparam logic [2:0] KIND_REPLY    = 3'd4;
   localparam logic [2:0] KIND_VERSION  = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;

   localparam logic [1:0] ERR_BUFFER_FULL = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG    = 2'd1;
   localparam logic [1:0] ERR_NO_DOT      = 2'd2;
   localparam logic [1:0] ERR_POS_WIDTH   = 2'd3;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_Z     = 8'h5A;

   // line slots that decoding ever reads
   localparam int SLOTS = 8;
   // numeric text with the dot removed
   localparam int TEXT_LEN = 4;
   localparam int NUM_TEXT_MAX = 6;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_SINGLE,
      CLS_REPLY,
      CLS_SETPOINT
   } cls_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic step;
      logic load_rsp;
   } rcp_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    step_last;
      logic    rsp_free;
      logic    final_item;
   } rcp_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/rcp_if.sv -----
// Channel interfaces of the rotator command parser: request and response.
// Depends on nothing; used by the top level.
`default_nettype none

interface rcp_req_if;
   logic               valid;
   logic               ready;
   logic [7:0]         rx_byte;
   logic signed [15:0] az_position;
   logic signed [15:0] el_position;

   modport source(output valid, rx_byte, az_position, el_position, input ready);
   modport sink(input valid, rx_byte, az_position, el_position, output ready);
endinterface

interface rcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic               axis;
   logic signed [14:0] setpoint;
   logic [7:0]         reply_byte;
   logic [1:0]         error_code;
   logic               last;

   modport source(output valid, kind, axis, setpoint, reply_byte, error_code, last,
                  input ready);
   modport sink(input valid, kind, axis, setpoint, reply_byte, error_code, last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rcp_ctrl.sv -----
// Controller of the rotator command parser: sequences accept, decode,
// iteration and result emission. Depends on rcp_pkg.
`default_nettype none

module rcp_ctrl import rcp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rcp_status_type status,
   output rcp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_DIGIT  = 5'b00100,
      ST_PARSE  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            unique case (status.cls)
               CLS_NONE:     state_in = ST_IDLE;
               CLS_SINGLE:   state_in = ST_EMIT;
               CLS_REPLY:    state_in = ST_DIGIT;
               CLS_SETPOINT: state_in = ST_PARSE;
            endcase
         end
         ST_DIGIT, ST_PARSE: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               if (status.final_item) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rcp_dp.sv -----
// Datapath of the rotator command parser: line slots, command decode,
// digit extraction, number parsing and the output register. Depends on rcp_pkg.
`default_nettype none

module rcp_dp import rcp_pkg::*; #(
   parameter int LINE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  rcp_cmd_type        cmd,
   output rcp_status_type     status,
   input  logic [7:0]         rx_byte,
   input  logic signed [15:0] az_position,
   input  logic signed [15:0] el_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic               rsp_axis,
   output logic signed [14:0] rsp_setpoint,
   output logic [7:0]         rsp_reply_byte,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam logic [31:0] DIV10_MUL = 32'd52429;
   localparam int DIV10_SHIFT = 19;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [7:0]         slot_ff [SLOTS];
   logic [IDX_W-1:0]   line_w_ff;
   logic [7:0]         byte_ff;
   logic signed [15:0] az_ff, el_ff;

   cls_type            mode_ff, cls;
   logic [2:0]         single_kind_ff, single_kind;
   logic               single_axis_ff, single_axis;
   logic [1:0]         single_err_ff, single_err;
   logic               axis_ff;
   logic [1:0]         step_ff;
   logic [2:0]         emit_idx_ff;

   logic [15:0]        mag_ff;
   logic               neg_ff;
   logic [3:0]         dig_ff [4];
   logic [31:0]        prod;
   logic [15:0]        quot, quot_x10;
   logic [3:0]         rem;

   logic [7:0]         text_ff [TEXT_LEN];
   logic [7:0]         text_in [TEXT_LEN];
   logic [13:0]        pv_ff, pv_in;
   logic               pneg_ff, pneg_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         ch;
   logic               ch_digit, ch_blank;
   logic [3:0]         ch_val;

   logic               full, sep, is_az, is_el, found, too_long, dot_ok;
   logic [2:0]         len;
   logic signed [15:0] pos_sel;

   logic [2:0]         nd;
   logic               err3;
   logic [3:0]         reply_n;
   logic [2:0]         j, k;
   logic [7:0]         reply_char;
   logic [14:0]        setp_mag;

   logic [2:0]         out_kind;
   logic               out_axis;
   logic [14:0]        out_setp;
   logic [7:0]         out_reply;
   logic [1:0]         out_err;
   logic               rsp_valid_ff;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
   endfunction

   // line storage and write index
   assign full      = (line_w_ff == IDX_W'(LINE_DEPTH - 1));
   assign wr_idx_in = ((wr_idx_ff == IDX_W'(LINE_DEPTH - 1)) || is_sep(rx_byte)) ?
                      '0 : wr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
      end else if (cmd.accept) begin
         wr_idx_ff <= wr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS; s++) begin
         if (cmd.accept && wr_idx_ff == IDX_W'(s)) begin
            slot_ff[s] <= rx_byte;
         end
      end
      if (cmd.accept) begin
         line_w_ff <= wr_idx_ff;
         byte_ff   <= rx_byte;
         az_ff     <= az_position;
         el_ff     <= el_position;
      end
   end

   // decode
   assign sep   = is_sep(byte_ff);
   assign is_az = (slot_ff[0] == CH_A) && (slot_ff[1] == CH_Z);
   assign is_el = (slot_ff[0] == CH_E) && (slot_ff[1] == CH_L);

   always_comb begin
      len   = 3'(NUM_TEXT_MAX);
      found = 1'b0;
      for (int s = 2; s < SLOTS; s++) begin
         if (!found && !((IDX_W'(s) < line_w_ff) && (slot_ff[s] != 8'd0))) begin
            len   = 3'(s - 2);
            found = 1'b1;
         end
      end
   end

   assign too_long = (len == 3'(NUM_TEXT_MAX));

   always_comb begin
      dot_ok = 1'b0;
      for (int s = 2; s < NUM_TEXT_MAX; s++) begin
         if (len == 3'(s) && slot_ff[s] == CH_DOT) begin
            dot_ok = 1'b1;
         end
      end
   end

   always_comb begin
      for (int t = 0; t < TEXT_LEN; t++) begin
         text_in[t] = 8'd0;
      end
      case (len)
         3'd2: text_in[0] = slot_ff[3];
         3'd3: begin
            text_in[0] = slot_ff[2];
            text_in[1] = slot_ff[4];
         end
         3'd4: begin
            text_in[0] = slot_ff[2];
            text_in[1] = slot_ff[3];
            text_in[2] = slot_ff[5];
         end
         3'd5: begin
            text_in[0] = slot_ff[2];
            text_in[1] = slot_ff[3];
            text_in[2] = slot_ff[4];
            text_in[3] = slot_ff[6];
         end
         default: text_in[0] = 8'd0;
      endcase
   end

   always_comb begin
      cls         = CLS_NONE;
      single_kind = KIND_ERROR;
      single_axis = 1'b0;
      single_err  = ERR_BUFFER_FULL;
      if (full) begin
         cls = CLS_SINGLE;
      end else if (sep) begin
         if (is_az || is_el) begin
            if (line_w_ff == IDX_W'(2)) begin
               cls = CLS_REPLY;
            end else if (too_long) begin
               cls        = CLS_SINGLE;
               single_err = ERR_TOO_LONG;
            end else if (!dot_ok) begin
               cls        = CLS_SINGLE;
               single_err = ERR_NO_DOT;
            end else begin
               cls = CLS_SETPOINT;
            end
         end else if (slot_ff[0] == CH_V && slot_ff[1] == CH_E) begin
            cls         = CLS_SINGLE;
            single_kind = KIND_VERSION;
         end else if (slot_ff[0] == CH_M) begin
            case (slot_ff[1])
               CH_L: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_MOVE_NEG;
               end
               CH_R: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_MOVE_POS;
               end
               CH_U: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_MOVE_POS;
                  single_axis = 1'b1;
               end
               CH_D: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_MOVE_NEG;
                  single_axis = 1'b1;
               end
               default: cls = CLS_NONE;
            endcase
         end else if (slot_ff[0] == CH_S) begin
            case (slot_ff[1])
               CH_A: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_STOP;
               end
               CH_E: begin
                  cls         = CLS_SINGLE;
                  single_kind = KIND_STOP;
                  single_axis = 1'b1;
               end
               default: cls = CLS_NONE;
            endcase
         end
      end
   end

   assign pos_sel = is_el ? el_ff : az_ff;

   // digit extraction: one decimal digit per step
   assign prod     = 32'(mag_ff) * DIV10_MUL;
   assign quot     = 16'(prod >> DIV10_SHIFT);
   assign quot_x10 = 16'(quot * 16'd10);
   assign rem      = 4'(mag_ff - quot_x10);

   // number parsing: one character per step
   assign ch       = text_ff[0];
   assign ch_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign ch_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                     (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
   assign ch_val   = 4'(ch - CH_ZERO);

   always_comb begin
      pv_in    = pv_ff;
      pneg_in  = pneg_ff;
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LEAD: begin
            if (ch_digit) begin
               pv_in    = 14'(ch_val);
               phase_in = PH_DIGITS;
            end else if (ch == CH_PLUS || ch == CH_MINUS) begin
               pneg_in  = (ch == CH_MINUS);
               phase_in = PH_DIGITS;
            end else if (!ch_blank) begin
               phase_in = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (ch_digit) begin
               pv_in = 14'({pv_ff, 3'b000} + {pv_ff, 1'b0} + 17'(ch_val));
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: phase_in = PH_DONE;
         default: phase_in = PH_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         mode_ff        <= cls;
         single_kind_ff <= single_kind;
         single_axis_ff <= single_axis;
         single_err_ff  <= single_err;
         axis_ff        <= is_el;
         step_ff        <= 2'd0;
         emit_idx_ff    <= 3'd0;
         neg_ff         <= pos_sel < 0;
         mag_ff         <= (pos_sel < 0) ? 16'(-pos_sel) : 16'(pos_sel);
         for (int t = 0; t < TEXT_LEN; t++) begin
            text_ff[t] <= text_in[t];
         end
         pv_ff    <= 14'd0;
         pneg_ff  <= 1'b0;
         phase_ff <= PH_LEAD;
      end else begin
         if (cmd.step) begin
            step_ff <= step_ff + 2'd1;
            mag_ff  <= quot;
            dig_ff[3] <= rem;
            for (int d = 0; d < 3; d++) begin
               dig_ff[d] <= dig_ff[d + 1];
            end
            for (int t = 0; t < TEXT_LEN - 1; t++) begin
               text_ff[t] <= text_ff[t + 1];
            end
            text_ff[TEXT_LEN - 1] <= 8'd0;
            pv_ff    <= pv_in;
            pneg_ff  <= pneg_in;
            phase_ff <= phase_in;
         end
         if (cmd.load_rsp) begin
            emit_idx_ff <= emit_idx_ff + 3'd1;
         end
      end
   end

   // position reply text
   always_comb begin
      if (dig_ff[3] != 4'd0) begin
         nd = 3'd4;
      end else if (dig_ff[2] != 4'd0) begin
         nd = 3'd3;
      end else if (dig_ff[1] != 4'd0) begin
         nd = 3'd2;
      end else begin
         nd = 3'd1;
      end
   end

   assign err3    = (mag_ff != 16'd0) || (neg_ff && nd == 3'd4);
   assign reply_n = 4'(nd) + 4'(neg_ff) + 4'd4;
   assign j       = emit_idx_ff - 3'd2;
   assign k       = j - 3'(neg_ff);

   always_comb begin
      if (emit_idx_ff == 3'd0) begin
         reply_char = slot_ff[0];
      end else if (emit_idx_ff == 3'd1) begin
         reply_char = slot_ff[1];
      end else if ({1'b0, emit_idx_ff} == reply_n - 4'd1) begin
         reply_char = slot_ff[2];
      end else if (neg_ff && j == 3'd0) begin
         reply_char = CH_MINUS;
      end else if (k == nd - 3'd1) begin
         reply_char = CH_DOT;
      end else if (k == nd) begin
         reply_char = CH_ZERO + 8'(dig_ff[0]);
      end else begin
         reply_char = CH_ZERO + 8'(dig_ff[2'(nd - 3'd1 - k)]);
      end
   end

   assign setp_mag = {1'b0, pv_ff};

   always_comb begin
      out_kind  = KIND_ERROR;
      out_axis  = 1'b0;
      out_setp  = 15'd0;
      out_reply = 8'd0;
      out_err   = ERR_BUFFER_FULL;
      case (mode_ff)
         CLS_SINGLE: begin
            out_kind = single_kind_ff;
            out_axis = single_axis_ff;
            out_err  = single_err_ff;
         end
         CLS_REPLY: begin
            if (err3) begin
               out_err = ERR_POS_WIDTH;
            end else begin
               out_kind  = KIND_REPLY;
               out_axis  = axis_ff;
               out_reply = reply_char;
            end
         end
         CLS_SETPOINT: begin
            out_kind = KIND_SETPOINT;
            out_axis = axis_ff;
            out_setp = pneg_ff ? 15'(-setp_mag) : setp_mag;
         end
         default: out_kind = KIND_ERROR;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_kind       <= out_kind;
         rsp_axis       <= out_axis;
         rsp_setpoint   <= out_setp;
         rsp_reply_byte <= out_reply;
         rsp_error_code <= out_err;
         rsp_last       <= status.final_item;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.cls        = cls;
   assign status.step_last  = (step_ff == 2'd3);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.final_item = (mode_ff != CLS_REPLY) || err3 ||
                              ({1'b0, emit_idx_ff} == reply_n - 4'd1);

endmodule

`default_nettype wire

// ----- rtl/core/rotator_command_parser.sv -----
// Rotator command parser top level: joins controller and datapath.
// Depends on rcp_pkg, rcp_if, rcp_ctrl and rcp_dp.
//
// Usage: received characters enter on req_chan together with the current
// azimuth and elevation positions; decoded events leave on rsp_chan, one
// item per result, with last set on the final item a character causes.
// Line ends (newline, carriage return, space) trigger decoding.
// Timing: one item is handled at a time. After acceptance a decode state
// follows; a plain character or unknown line then frees the input.
// A setpoint then runs parse steps and a position reply digit steps
// (one decimal digit per cycle through a multiply-by-reciprocal unit),
// then results load the output register at one per cycle while the
// receiver keeps up: up to 8 for a reply.
// The output register decouples the sides: the last result may wait on
// rsp_chan while the next character is accepted. A stalled receiver holds
// emission, and with it the input, until the register frees.
// Reset clears the write index, the controller and the output valid;
// line contents are not cleared.
`default_nettype none

module rotator_command_parser import rcp_pkg::*; #(
   parameter int LINE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   rcp_req_if.sink    req_chan,
   rcp_rsp_if.source  rsp_chan
);

   rcp_cmd_type    cmd;
   rcp_status_type status;

   rcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcp_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .rx_byte        (req_chan.rx_byte),
      .az_position    (req_chan.az_position),
      .el_position    (req_chan.el_position),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_kind       (rsp_chan.kind),
      .rsp_axis       (rsp_chan.axis),
      .rsp_setpoint   (rsp_chan.setpoint),
      .rsp_reply_byte (rsp_chan.reply_byte),
      .rsp_error_code (rsp_chan.error_code),
      .rsp_last       (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ----- rtl/core/rcp_checker.sv -----
// Port-level checks for the rotator command parser and the bind that
// attaches them to the top level. Depends on rcp_pkg.
`default_nettype none

module rcp_port_assert import rcp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_kind,
   input logic              rsp_axis,
   input logic signed [14:0] rsp_setpoint,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted before the first was handled");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REPLY |-> rsp_last)
      else $error("non-reply result not marked last");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> !rsp_axis && rsp_setpoint == 15'sd0)
      else $error("error result carries axis or setpoint");

endmodule

bind rotator_command_parser rcp_port_assert u_rcp_port_assert (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_axis     (rsp_chan.axis),
   .rsp_setpoint (rsp_chan.setpoint),
   .rsp_last     (rsp_chan.last)
);

`default_nettype wire

// ----- test/rcp_checker.sv -----
// Checker for the rotator command parser: watches both channels, predicts results.
// Depends on rcp_pkg and the rcp_req_if / rcp_rsp_if interfaces.
`default_nettype none

module rcp_checker import rcp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   rcp_req_if    req,
   rcp_rsp_if    rsp,
   output int    fail_count,
   output int    pending
);

   typedef struct packed {
      logic [2:0]         kind;
      logic               axis;
      logic signed [14:0] setpoint;
      logic [7:0]         reply_byte;
      logic [1:0]         error_code;
      logic               last;
   } outcome_type;

   localparam int DEPTH = 16;

   outcome_type expected_q[$];
   outcome_type step_q[$];
   logic [7:0]  line_mem [DEPTH];
   int          wr_idx;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic void add(input logic [2:0] kind, input logic axis,
                               input int sp, input logic [7:0] rb, input logic [1:0] ec);
      outcome_type o;
      o.kind = kind;
      o.axis = axis;
      o.setpoint = sp[14:0];
      o.reply_byte = rb;
      o.error_code = ec;
      o.last = 1'b0;
      step_q.push_back(o);
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
             || c == CH_CR;
   endfunction

   function automatic void position_text(input logic axis, input int pos);
      logic [7:0] digits [8];
      int nd, mag, k;
      bit neg;
      nd = 0;
      neg = pos < 0;
      mag = neg ? -pos : pos;
      do begin
         digits[nd] = CH_ZERO + 8'(mag % 10);
         nd++;
         mag = mag / 10;
      end while (mag != 0 && nd < 8);
      if (nd + (neg ? 1 : 0) >= NUM_TEXT_MAX - 1) begin
         add(KIND_ERROR, 1'b0, 0, 8'd0, ERR_POS_WIDTH);
         return;
      end
      add(KIND_REPLY, axis, 0, line_mem[0], 2'd0);
      add(KIND_REPLY, axis, 0, line_mem[1], 2'd0);
      if (neg) add(KIND_REPLY, axis, 0, CH_MINUS, 2'd0);
      for (k = nd; k > 1; k--) add(KIND_REPLY, axis, 0, digits[k-1], 2'd0);
      add(KIND_REPLY, axis, 0, CH_DOT, 2'd0);
      add(KIND_REPLY, axis, 0, digits[0], 2'd0);
      add(KIND_REPLY, axis, 0, line_mem[2], 2'd0);
   endfunction

   function automatic void axis_line(input logic axis, input int pos);
      logic [7:0] txt [NUM_TEXT_MAX];
      int len, k, i, v, n;
      bit neg;
      if (wr_idx == 2) begin
         position_text(axis, pos);
         return;
      end
      line_mem[wr_idx] = 8'd0;
      len = 0;
      while (len < NUM_TEXT_MAX && 2 + len < DEPTH && line_mem[2+len] != 8'd0) len++;
      if (len >= NUM_TEXT_MAX) begin
         add(KIND_ERROR, 1'b0, 0, 8'd0, ERR_TOO_LONG);
         return;
      end
      if (len < 2 || line_mem[len] != CH_DOT) begin
         add(KIND_ERROR, 1'b0, 0, 8'd0, ERR_NO_DOT);
         return;
      end
      for (k = 0; k + 2 < len; k++) txt[k] = line_mem[2+k];
      txt[len-2] = line_mem[len+1];
      n = len - 1;
      i = 0;
      v = 0;
      neg = 0;
      while (i < n && is_blank(txt[i])) i++;
      if (i < n && (txt[i] == CH_PLUS || txt[i] == CH_MINUS)) begin
         neg = txt[i] == CH_MINUS;
         i++;
      end
      while (i < n && txt[i] >= CH_ZERO && txt[i] <= CH_NINE) begin
         v = v * 10 + int'(txt[i] - CH_ZERO);
         i++;
      end
      add(KIND_SETPOINT, axis, neg ? -v : v, 8'd0, 2'd0);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input int az, input int el);
      logic [7:0] c0, c1;
      step_q.delete();
      if (wr_idx >= DEPTH) wr_idx = 0;
      line_mem[wr_idx] = b;
      if (wr_idx == DEPTH - 1) begin
         add(KIND_ERROR, 1'b0, 0, 8'd0, ERR_BUFFER_FULL);
         wr_idx = 0;
      end else if (b == CH_LF || b == CH_CR || b == CH_SPACE) begin
         c0 = line_mem[0];
         c1 = line_mem[1];
         if (c0 == CH_A && c1 == CH_Z) axis_line(1'b0, az);
         else if (c0 == CH_E && c1 == CH_L) axis_line(1'b1, el);
         else if (c0 == CH_V && c1 == CH_E) add(KIND_VERSION, 1'b0, 0, 8'd0, 2'd0);
         else if (c0 == CH_M) begin
            if (c1 == CH_L) add(KIND_MOVE_NEG, 1'b0, 0, 8'd0, 2'd0);
            else if (c1 == CH_R) add(KIND_MOVE_POS, 1'b0, 0, 8'd0, 2'd0);
            else if (c1 == CH_U) add(KIND_MOVE_POS, 1'b1, 0, 8'd0, 2'd0);
            else if (c1 == CH_D) add(KIND_MOVE_NEG, 1'b1, 0, 8'd0, 2'd0);
         end else if (c0 == CH_S) begin
            if (c1 == CH_A) add(KIND_STOP, 1'b0, 0, 8'd0, 2'd0);
            else if (c1 == CH_E) add(KIND_STOP, 1'b1, 0, 8'd0, 2'd0);
         end
         wr_idx = 0;
      end else begin
         wr_idx++;
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[k]) expected_q.push_back(step_q[k]);
   endfunction

   assign pending = expected_q.size();

   initial begin
      fail_count = 0;
      wr_idx = 0;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         wr_idx = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report($sformatf("unexpected item kind %0d", rsp.kind));
            end else begin
               want = expected_q.pop_front();
               if (rsp.kind !== want.kind)
                  report($sformatf("kind %0d, want %0d", rsp.kind, want.kind));
               if (rsp.axis !== want.axis)
                  report($sformatf("axis %0d, want %0d", rsp.axis, want.axis));
               if (rsp.setpoint !== want.setpoint)
                  report($sformatf("setpoint %0d, want %0d", rsp.setpoint, want.setpoint));
               if (rsp.reply_byte !== want.reply_byte)
                  report($sformatf("reply %h, want %h", rsp.reply_byte, want.reply_byte));
               if (rsp.error_code !== want.error_code)
                  report($sformatf("error %0d, want %0d", rsp.error_code, want.error_code));
               if (rsp.last !== want.last)
                  report($sformatf("last %0d, want %0d", rsp.last, want.last));
            end
         end
         if (req.valid && req.ready)
            decode_byte(req.rx_byte, int'(req.az_position), int'(req.el_position));
      end
   end

endmodule

`default_nettype wire

// ----- test/tb_rotator_command_parser.sv -----
// Testbench top for the rotator command parser: clock, reset, stimulus, verdict.
// Depends on rcp_pkg, rcp_if, the block and rcp_checker.
`default_nettype none

module tb_rotator_command_parser;
   import rcp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   idle_pct = 0, stall_pct = 0, hold_left = 0, hold_ask = 0, sent = 0;
   logic hold_kick = 1'b0;
   logic [7:0] line_q[$];

   rcp_req_if req_chan();
   rcp_rsp_if rsp_chan();

   rotator_command_parser uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   rcp_checker chk (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .fail_count(fail_count), .pending(pending));

   always #2 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'd0;
      req_chan.az_position = 16'sd0;
      req_chan.el_position = 16'sd0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_kick) begin
         hold_left <= hold_ask;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= $urandom_range(99) >= stall_pct;
      end
   end

   function automatic logic [15:0] pick_pos();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom);
         3: return 16'($signed($urandom_range(1100)) - 1100);
         4: return 16'($urandom_range(10100, 9900));
         default: return 16'($signed($urandom_range(10998)) - 999);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [15:0] az, input logic [15:0] el);
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      req_chan.az_position <= az;
      req_chan.el_position <= el;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic send_line(input logic [15:0] az, input logic [15:0] el);
      foreach (line_q[k]) begin
         if (k == line_q.size() - 1) send_byte(line_q[k], az, el);
         else send_byte(line_q[k], pick_pos(), pick_pos());
      end
      line_q.delete();
   endtask

   function automatic logic [7:0] pick_end();
      case ($urandom_range(2))
         0: return CH_LF;
         1: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   // build one random line in line_q
   task automatic make_line();
      int n;
      logic [7:0] ax0, ax1;
      if ($urandom_range(1)) begin
         ax0 = CH_A; ax1 = CH_Z;
      end else begin
         ax0 = CH_E; ax1 = CH_L;
      end
      case ($urandom_range(11))
         0, 1: line_q = '{ax0, ax1, pick_end()};
         2, 3: begin
            line_q = '{ax0, ax1};
            case ($urandom_range(3))
               0: line_q.push_back(CH_MINUS);
               1: line_q.push_back(CH_PLUS);
               2: line_q.push_back(CH_TAB);
               default: ;
            endcase
            n = $urandom_range(3);
            repeat (n) line_q.push_back(pick_digit());
            line_q.push_back(CH_DOT);
            line_q.push_back(pick_digit());
            line_q.push_back(pick_end());
         end
         4: begin
            line_q = '{ax0, ax1};
            n = $urandom_range(8);
            repeat (n) begin
               case ($urandom_range(4))
                  0: line_q.push_back(CH_DOT);
                  1: line_q.push_back(8'd0);
                  2: line_q.push_back(CH_MINUS);
                  default: line_q.push_back(pick_digit());
               endcase
            end
            line_q.push_back(pick_end());
         end
         5: begin
            case ($urandom_range(3))
               0: line_q = '{CH_M, CH_L};
               1: line_q = '{CH_M, CH_R};
               2: line_q = '{CH_M, CH_U};
               default: line_q = '{CH_M, CH_D};
            endcase
            line_q.push_back(pick_end());
         end
         6: begin
            case ($urandom_range(2))
               0: line_q = '{CH_S, CH_A};
               1: line_q = '{CH_S, CH_E};
               default: line_q = '{CH_V, CH_E};
            endcase
            line_q.push_back(pick_end());
         end
         7: line_q = '{($urandom_range(1) ? CH_M : CH_S), 8'($urandom), pick_end()};
         8: begin
            n = $urandom_range(20, 14);
            repeat (n) line_q.push_back(8'($urandom_range(255, 33)));
            line_q.push_back(pick_end());
         end
         9: line_q = '{pick_end()};
         10: line_q = '{8'($urandom)};
         default: begin
            n = $urandom_range(3, 1);
            repeat (n) line_q.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic run_phase(input int idle, input int stall, input int items, input bit squeeze);
      idle_pct = idle;
      stall_pct = stall;
      items += sent;
      while (sent < items) begin
         if (squeeze && sent + 40 > items - 60 && hold_ask == 0) begin
            hold_ask = 300;
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
         make_line();
         send_line(pick_pos(), pick_pos());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      line_q = '{CH_V, CH_E, CH_LF};
      send_line(16'sd0, 16'sd0);
      line_q = '{CH_A, CH_Z, CH_CR};
      send_line(16'sd9999, 16'sd0);
      line_q = '{CH_E, CH_L, CH_SPACE};
      send_line(16'sd0, -16'sd999);
      line_q = '{CH_A, CH_Z, CH_LF};
      send_line(16'h8000, 16'sd0);
      line_q = '{CH_E, CH_L, CH_MINUS, CH_NINE, CH_DOT, CH_NINE, CH_LF};
      send_line(16'sd0, 16'sd0);
      line_q = '{CH_LF};
      send_line(16'sd5, -16'sd5);
      run_phase(0, 0, 100, 0);
      run_phase(60, 0, 100, 1);
      run_phase(0, 60, 100, 0);
      run_phase(9, 9, 90, 0);
      req_chan.valid <= 1'b0;
      while (pending > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
